// ----- rtl/assert_macros.svh -----
// Assertion macros used by rsi_indicator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ----- rtl/rsi_pkg.sv -----
// Types and constants of the relative strength index block
package rsi_pkg;

    // Width of the period register
    localparam int PERIOD_W = 10;

    // Width of the index result, full scale is 100.0 in units of 1/256
    localparam int RSI_W = 15;
    localparam logic [RSI_W-1:0] RSI_FULL = 15'd25600;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADDX,
        ST_DIV,
        ST_RPREP,
        ST_RDIV,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/rsi_indicator.sv -----
// Wilder relative strength index over a stream of prices, bit-serial datapath
// Sequence per request: first and warm-up samples go straight to the done state; the initial
//   averages divide the sums by the period, smoothing first multiplies by period - 1 and adds
//   the change; then the index division runs unless the average loss is zero.
// A new request is taken only once the result has been loaded into the output register.
// Reset: synchronous, active low; period returns to 14 and all stream state clears.
`include "assert_macros.svh"

module rsi_indicator #(
    parameter int PRICE_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    parameter int MAX_PERIOD  = 1023
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write
    input  logic                          i_cfg_we,
    input  logic [rsi_pkg::PERIOD_W-1:0]  i_cfg_wdata,
    // price requests
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [PRICE_WIDTH-1:0]        i_price,
    // index results
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_rsi_valid,
    output logic [rsi_pkg::RSI_W-1:0]     o_rsi_value
);

    localparam int PW     = rsi_pkg::PERIOD_W;
    localparam int RW     = rsi_pkg::RSI_W;
    localparam int AVG_W  = PRICE_WIDTH + FRAC_BITS;
    localparam int SUM_W  = PRICE_WIDTH + PW;
    localparam int DIV_W  = AVG_W + PW + 1;
    localparam int NUM_W  = AVG_W + RW;
    localparam int CNT_W  = $clog2(DIV_W + 1);

    // state and stream registers
    rsi_pkg::t_state    r_state, n_state;
    logic [PW-1:0]      r_period;
    logic [PW:0]        r_count;
    logic [PRICE_WIDTH-1:0] r_prev;
    logic [SUM_W-1:0]   r_gsum, r_lsum;
    logic [AVG_W-1:0]   r_avg_g, r_avg_l;

    // working registers
    logic [PRICE_WIDTH-1:0] r_up, r_dn;
    logic [DIV_W-1:0]   r_dq_g, r_dq_l;
    logic [PW-1:0]      r_rem_g, r_rem_l;
    logic [PW-1:0]      r_mbits;
    logic [CNT_W-1:0]   r_cnt;
    logic [AVG_W:0]     r_rrem;
    logic [AVG_W:0]     r_den;
    logic [RW-1:0]      r_nlo;
    logic               r_res_valid;
    logic [RW-1:0]      r_res_value;

    // output register
    logic               r_o_valid;
    logic               r_o_rsi_valid;
    logic [RW-1:0]      r_o_rsi_value;

    // control
    logic               w_accept;
    logic               w_load_out;
    logic               w_last;
    logic [PW-1:0]      w_p;
    logic               w_first, w_warm, w_init;
    logic [PRICE_WIDTH-1:0] w_up, w_dn;
    logic [SUM_W-1:0]   w_gsum, w_lsum;

    // datapath steps
    logic [PW:0]        w_tg, w_tl;
    logic               w_ge_g, w_ge_l;
    logic [DIV_W-1:0]   w_mac_g, w_mac_l;
    logic [NUM_W-1:0]   w_num;
    logic [AVG_W+1:0]   w_rt;
    logic               w_rge;

    // Clamp the period to the supported range, zero counts as one
    always_comb begin
        w_p = r_period;
        if (int'(r_period) > MAX_PERIOD) begin
            w_p = PW'(MAX_PERIOD);
        end
        if (w_p == '0) begin
            w_p = PW'(1);
        end
    end

    // Classify the request and form the price change
    always_comb begin
        w_first = (r_count == '0);
        w_warm  = (r_count <= {1'b0, w_p});
        w_init  = (r_count == {1'b0, w_p});
        if (i_price > r_prev) begin
            w_up = i_price - r_prev;
            w_dn = '0;
        end else begin
            w_up = '0;
            w_dn = r_prev - i_price;
        end
        w_gsum = r_gsum + SUM_W'(w_up);
        w_lsum = r_lsum + SUM_W'(w_dn);
    end

    // One restoring step per lane for division by the period
    always_comb begin
        w_tg   = {r_rem_g, r_dq_g[DIV_W-1]};
        w_tl   = {r_rem_l, r_dq_l[DIV_W-1]};
        w_ge_g = (w_tg >= {1'b0, w_p});
        w_ge_l = (w_tl >= {1'b0, w_p});
    end

    // One shift-add step of avg * (period - 1), multiplier bits MSB first
    always_comb begin
        w_mac_g = (r_dq_g << 1) + (r_mbits[PW-1] ? DIV_W'(r_avg_g) : '0);
        w_mac_l = (r_dq_l << 1) + (r_mbits[PW-1] ? DIV_W'(r_avg_l) : '0);
    end

    // Numerator for the index and one restoring step of its division;
    // full scale 25600 is 2^14 + 2^13 + 2^10, so scale by three shifted adds
    always_comb begin
        w_num = (NUM_W'(r_avg_g) << 14) + (NUM_W'(r_avg_g) << 13)
              + (NUM_W'(r_avg_g) << 10);
        w_rt  = {r_rrem, r_nlo[RW-1]};
        w_rge = (w_rt >= {1'b0, r_den});
    end

    assign w_last = (r_cnt == CNT_W'(1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rsi_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (w_first || (w_warm && !w_init)) begin
                        n_state = rsi_pkg::ST_DONE;
                    end else if (w_init) begin
                        n_state = rsi_pkg::ST_DIV;
                    end else begin
                        n_state = rsi_pkg::ST_MUL;
                    end
                end
            end
            rsi_pkg::ST_MUL: begin
                if (w_last) begin
                    n_state = rsi_pkg::ST_ADDX;
                end
            end
            rsi_pkg::ST_ADDX: begin
                n_state = rsi_pkg::ST_DIV;
            end
            rsi_pkg::ST_DIV: begin
                if (w_last) begin
                    n_state = rsi_pkg::ST_RPREP;
                end
            end
            rsi_pkg::ST_RPREP: begin
                if (r_avg_l == '0) begin
                    n_state = rsi_pkg::ST_DONE;
                end else begin
                    n_state = rsi_pkg::ST_RDIV;
                end
            end
            rsi_pkg::ST_RDIV: begin
                if (w_last) begin
                    n_state = rsi_pkg::ST_DONE;
                end
            end
            rsi_pkg::ST_DONE: begin
                if (w_load_out) begin
                    n_state = rsi_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rsi_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake outputs of the sequencer
    always_comb begin
        o_ready    = (r_state == rsi_pkg::ST_IDLE);
        w_load_out = (r_state == rsi_pkg::ST_DONE) && (!r_o_valid || i_ready);
    end

    assign w_accept = i_valid && o_ready;

    // Advance the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsi_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold period and stream state; a period write starts a new stream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PW'(14);
            r_count  <= '0;
            r_prev   <= '0;
            r_gsum   <= '0;
            r_lsum   <= '0;
            r_avg_g  <= '0;
            r_avg_l  <= '0;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_wdata;
            r_count  <= '0;
            r_prev   <= '0;
            r_gsum   <= '0;
            r_lsum   <= '0;
            r_avg_g  <= '0;
            r_avg_l  <= '0;
        end else begin
            if (w_accept) begin
                r_prev <= i_price;
                if (w_first) begin
                    r_count <= (PW+1)'(1);
                end else if (w_warm) begin
                    r_gsum  <= w_gsum;
                    r_lsum  <= w_lsum;
                    r_count <= r_count + (PW+1)'(1);
                end else begin
                    r_count <= {1'b0, w_p} + (PW+1)'(1);
                end
            end
            // drop the quotients into the averages on the final step
            if (r_state == rsi_pkg::ST_DIV && w_last) begin
                r_avg_g <= AVG_W'({r_dq_g[DIV_W-2:0], w_ge_g});
                r_avg_l <= AVG_W'({r_dq_l[DIV_W-2:0], w_ge_l});
            end
        end
    end

    // Working datapath, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            rsi_pkg::ST_IDLE: begin
                r_up    <= w_up;
                r_dn    <= w_dn;
                r_rem_g <= '0;
                r_rem_l <= '0;
                r_res_valid <= 1'b0;
                r_res_value <= '0;
                if (w_init) begin
                    r_dq_g <= DIV_W'(w_gsum) << FRAC_BITS;
                    r_dq_l <= DIV_W'(w_lsum) << FRAC_BITS;
                    r_cnt  <= CNT_W'(DIV_W);
                end else begin
                    r_dq_g <= '0;
                    r_dq_l <= '0;
                    r_cnt  <= CNT_W'(PW);
                end
                r_mbits <= w_p - PW'(1);
            end
            rsi_pkg::ST_MUL: begin
                r_dq_g  <= w_mac_g;
                r_dq_l  <= w_mac_l;
                r_mbits <= r_mbits << 1;
                r_cnt   <= r_cnt - CNT_W'(1);
            end
            rsi_pkg::ST_ADDX: begin
                r_dq_g <= r_dq_g + (DIV_W'(r_up) << FRAC_BITS);
                r_dq_l <= r_dq_l + (DIV_W'(r_dn) << FRAC_BITS);
                r_cnt  <= CNT_W'(DIV_W);
            end
            rsi_pkg::ST_DIV: begin
                r_rem_g <= w_ge_g ? PW'(w_tg - {1'b0, w_p}) : PW'(w_tg);
                r_rem_l <= w_ge_l ? PW'(w_tl - {1'b0, w_p}) : PW'(w_tl);
                r_dq_g  <= {r_dq_g[DIV_W-2:0], w_ge_g};
                r_dq_l  <= {r_dq_l[DIV_W-2:0], w_ge_l};
                r_cnt   <= r_cnt - CNT_W'(1);
            end
            rsi_pkg::ST_RPREP: begin
                r_res_valid <= 1'b1;
                r_res_value <= '0;
                r_rrem <= {1'b0, w_num[NUM_W-1:RW]};
                r_nlo  <= w_num[RW-1:0];
                r_den  <= {1'b0, r_avg_g} + {1'b0, r_avg_l};
                r_cnt  <= CNT_W'(RW);
            end
            rsi_pkg::ST_RDIV: begin
                r_rrem <= w_rge ? (AVG_W+1)'(w_rt - {1'b0, r_den}) : (AVG_W+1)'(w_rt);
                r_nlo  <= {r_nlo[RW-2:0], w_rge};
                r_cnt  <= r_cnt - CNT_W'(1);
                if (w_last) begin
                    r_res_value <= {r_nlo[RW-2:0], w_rge};
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_rsi_valid <= r_res_valid;
            r_o_rsi_value <= r_res_value;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_rsi_valid = r_o_rsi_valid;
    assign o_rsi_value = r_o_rsi_value;

    // Checks on the sequencer and the result path
    `ASSERT_SAME(a_invalid_zero, i_clk, i_rst_n, o_valid && !o_rsi_valid, o_rsi_value == '0)
    `ASSERT_SAME(a_full_scale, i_clk, i_rst_n, o_valid, o_rsi_value <= rsi_pkg::RSI_FULL)
    `ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= ({1'b0, w_p} + (PW+1)'(1)))
    `ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, w_accept, r_state != rsi_pkg::ST_IDLE)

endmodule
